>>> src/scope_ring_trigger_capture_assert.svh
// Assertion macros shared by the scope capture modules.
// Needs clk and rst_n in the scope of the module that uses them.
`ifndef SCOPE_RING_TRIGGER_CAPTURE_ASSERT_SVH
`define SCOPE_RING_TRIGGER_CAPTURE_ASSERT_SVH

// Check cons in the same cycle as ante.
`define SRTC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante.
`define SRTC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/srtc_pkg.sv
// Shared types and constants of the scope ring capture block.
// No dependencies; used by every module of the block except srtc_ram.
package srtc_pkg;

    // Ring depth is a power of two: ring indexes wrap by truncation.
    localparam int RING_DEPTH = 1024;
    localparam int PTR_W      = $clog2(RING_DEPTH);
    localparam int HALF_DEPTH = RING_DEPTH / 2;
    localparam int OFF_W      = (PTR_W + 1 > 11) ? PTR_W + 1 : 11;

    localparam int SAMPLE_W   = 16;
    localparam int SEQ_W      = 32;
    localparam int TOP_W      = 10;
    localparam int HGT_W      = 11;
    localparam int OFS_W      = 10;
    localparam int COL_W      = 10;
    localparam int ROW_W      = 11;
    localparam int CFG_W      = 11;
    localparam int CFGIDX_W   = 2;

    localparam logic [TOP_W-1:0] PLOT_TOP_RST     = TOP_W'(44);
    localparam logic [HGT_W-1:0] PLOT_HEIGHT_RST  = HGT_W'(368);
    localparam logic [OFS_W-1:0] WINDOW_WIDTH_RST = OFS_W'(776);
    localparam logic [SEQ_W-1:0] STORED_SEQ_RST   = '1;

    localparam logic [CFGIDX_W-1:0] CFG_PLOT_TOP     = CFGIDX_W'(0);
    localparam logic [CFGIDX_W-1:0] CFG_PLOT_HEIGHT  = CFGIDX_W'(1);
    localparam logic [CFGIDX_W-1:0] CFG_WINDOW_WIDTH = CFGIDX_W'(2);

    localparam logic RPL_TRIGGER = 1'b0;
    localparam logic RPL_COLUMN  = 1'b1;

    typedef enum logic [1:0] {
        CMD_PUSH   = 2'd0,
        CMD_SEARCH = 2'd1,
        CMD_READ   = 2'd2,
        CMD_NOP    = 2'd3
    } srtc_op_t;

    // Controller to datapath
    typedef struct packed {
        logic take;      // request accepted this cycle
        logic prime;     // first search sample is on the RAM output
        logic step;      // older search sample is on the RAM output
        logic rd_calc;   // column sample is on the RAM output
        logic load_out;  // move the finished reply into the output register
    } srtc_ctl_t;

    // Datapath to controller
    typedef struct packed {
        logic hit;       // rising crossing found at the current offset
        logic last;      // current offset is the last one to check
    } srtc_sts_t;

endpackage

>>> src/srtc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module srtc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> src/srtc_ctrl.sv
// Controller of the scope ring capture: sequences push, search and column read.
// Depends on srtc_pkg and the assertion macro header.
`include "scope_ring_trigger_capture_assert.svh"

module srtc_ctrl
    import srtc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    input  logic [1:0] cmd,
    output logic       req_stall,
    output logic       rsp_valid,
    input  logic       rsp_stall,
    input  srtc_sts_t  sts,
    output srtc_ctl_t  ctl
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PR_MEM,
        S_PR_DATA,
        S_SR_MEM,
        S_SR_DATA,
        S_RD_MEM,
        S_RD_DATA,
        S_OUT
    } state_t;

    state_t   state_reg, state_next;
    logic     rsp_valid_reg, rsp_valid_next;
    logic     accept;
    logic     out_free;
    srtc_op_t op;

    assign op       = srtc_op_t'(cmd);
    assign accept   = req_valid && (state_reg == S_IDLE);
    assign out_free = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    unique case (op)
                        CMD_SEARCH: state_next = S_PR_MEM;
                        CMD_READ:   state_next = S_RD_MEM;
                        CMD_PUSH,
                        CMD_NOP:    state_next = S_IDLE;
                        default:    state_next = S_IDLE;
                    endcase
                end
            end
            S_PR_MEM:  state_next = S_PR_DATA;
            S_PR_DATA: state_next = S_SR_MEM;
            S_SR_MEM:  state_next = S_SR_DATA;
            S_SR_DATA: state_next = (sts.hit || sts.last) ? S_OUT : S_SR_MEM;
            S_RD_MEM:  state_next = S_RD_DATA;
            S_RD_DATA: state_next = S_OUT;
            S_OUT:     state_next = out_free ? S_IDLE : S_OUT;
            default:   state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        ctl.take     = accept;
        ctl.prime    = (state_reg == S_PR_DATA);
        ctl.step     = (state_reg == S_SR_DATA);
        ctl.rd_calc  = (state_reg == S_RD_DATA);
        ctl.load_out = (state_reg == S_OUT) && out_free;
    end

    // hold the reply while the receiver stalls, drop it once taken
    always_comb
    begin
        priority if (ctl.load_out)
            rsp_valid_next = 1'b1;
        else if (!rsp_stall)
            rsp_valid_next = 1'b0;
        else
            rsp_valid_next = rsp_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;

    `SRTC_ASSERT_NOW(a_load_when_free, ctl.load_out, !rsp_valid || !rsp_stall,
        "reply loaded over a stalled reply")
    `SRTC_ASSERT_NEXT(a_search_ends, (state_reg == S_SR_DATA) && (sts.hit || sts.last),
        state_reg == S_OUT, "search did not finish on hit or last offset")

endmodule

>>> src/srtc_dp.sv
// Datapath of the scope ring capture: config registers, sample ring,
// write pointer, trigger search registers, row mapping and reply register.
// Depends on srtc_pkg, srtc_ram and the assertion macro header.
`include "scope_ring_trigger_capture_assert.svh"

module srtc_dp
    import srtc_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  srtc_ctl_t                  ctl,
    output srtc_sts_t                  sts,
    input  logic [1:0]                 cmd,
    input  logic [SEQ_W-1:0]           packet_seq,
    input  logic signed [SAMPLE_W-1:0] left_sample,
    input  logic signed [SAMPLE_W-1:0] right_sample,
    input  logic [COL_W-1:0]           column,
    input  logic                       cfg_valid,
    input  logic [CFGIDX_W-1:0]        cfg_index,
    input  logic [CFG_W-1:0]           cfg_data,
    output logic                       reply_kind,
    output logic [OFS_W-1:0]           trigger_offset,
    output logic [ROW_W-1:0]           left_y,
    output logic [ROW_W-1:0]           right_y
);

    logic [TOP_W-1:0]  plot_top_reg;
    logic [HGT_W-1:0]  plot_height_reg;
    logic [OFS_W-1:0]  window_width_reg;
    logic [PTR_W-1:0]  wp_reg;
    logic              wrapped_reg;
    logic [SEQ_W-1:0]  stored_seq_reg;
    logic [OFS_W-1:0]  start_off_reg;

    logic [PTR_W-1:0]  idx_reg;
    logic [OFF_W-1:0]  off_reg;
    logic [PTR_W-1:0]  cnt_reg;
    logic              newer_ok_reg;
    logic              ent_ok_reg;
    logic              kind_reg;
    logic [ROW_W-1:0]  left_res_reg;
    logic [ROW_W-1:0]  right_res_reg;
    logic              reply_kind_reg;
    logic [OFS_W-1:0]  trigger_offset_reg;
    logic [ROW_W-1:0]  left_y_reg;
    logic [ROW_W-1:0]  right_y_reg;

    srtc_op_t                 op;
    logic                     ram_we;
    logic [2*SAMPLE_W-1:0]    ram_rdata;
    logic [SAMPLE_W-1:0]      rd_left;
    logic [SAMPLE_W-1:0]      rd_right;
    logic                     older_neg;
    logic [OFF_W-1:0]         w_ext;
    logic [OFF_W-1:0]         so_ext;
    logic [OFF_W-1:0]         col_ext;
    logic [OFF_W-1:0]         limit;
    logic [PTR_W-1:0]         search_idx;
    logic [PTR_W-1:0]         read_idx;

    // Map a Q1.15 sample to a screen row: top + floor((32768 - v) * h / 65536).
    function automatic logic [ROW_W-1:0] sample_row(
        input logic [SAMPLE_W-1:0] raw,
        input logic [TOP_W-1:0]    top,
        input logic [HGT_W-1:0]    hgt
    );
        logic [HGT_W-1:0]    h;
        logic [SAMPLE_W:0]   num;
        logic [SAMPLE_W+HGT_W:0] prod;
        logic [HGT_W:0]      q;
        logic [ROW_W+1:0]    y;
        h    = (hgt != '0) ? hgt - HGT_W'(1) : '0;
        // offset binary u = v + 32768, so 32768 - v = 65536 - u
        num  = {1'b1, {SAMPLE_W{1'b0}}} - {1'b0, raw ^ {1'b1, {(SAMPLE_W-1){1'b0}}}};
        prod = (SAMPLE_W+HGT_W+1)'(num) * (SAMPLE_W+HGT_W+1)'(h);
        q    = prod[SAMPLE_W+HGT_W:SAMPLE_W];
        y    = (ROW_W+2)'(top) + (ROW_W+2)'(q);
        sample_row = (y > (ROW_W+2)'({ROW_W{1'b1}})) ? {ROW_W{1'b1}} : y[ROW_W-1:0];
    endfunction

    assign op        = srtc_op_t'(cmd);
    assign ram_we    = ctl.take && (op == CMD_PUSH) && (packet_seq != stored_seq_reg);
    assign rd_left   = ram_rdata[2*SAMPLE_W-1:SAMPLE_W];
    assign rd_right  = ram_rdata[SAMPLE_W-1:0];
    assign older_neg = ent_ok_reg && rd_left[SAMPLE_W-1];

    assign w_ext      = OFF_W'(window_width_reg);
    assign so_ext     = OFF_W'(start_off_reg);
    assign col_ext    = OFF_W'(column);
    assign limit      = (OFF_W'(HALF_DEPTH) > w_ext) ? OFF_W'(HALF_DEPTH) - w_ext
                                                     : OFF_W'(1);
    assign search_idx = wp_reg - w_ext[PTR_W-1:0];
    assign read_idx   = wp_reg - so_ext[PTR_W-1:0] + col_ext[PTR_W-1:0];

    assign sts.hit  = older_neg && newer_ok_reg;
    assign sts.last = (cnt_reg == PTR_W'(1));

    srtc_ram #(
        .WIDTH (2 * SAMPLE_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wp_reg),
        .wdata ({left_sample, right_sample}),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plot_top_reg     <= PLOT_TOP_RST;
            plot_height_reg  <= PLOT_HEIGHT_RST;
            window_width_reg <= WINDOW_WIDTH_RST;
            wp_reg           <= '0;
            wrapped_reg      <= 1'b0;
            stored_seq_reg   <= STORED_SEQ_RST;
            start_off_reg    <= WINDOW_WIDTH_RST;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_PLOT_TOP:     plot_top_reg     <= cfg_data[TOP_W-1:0];
                    CFG_PLOT_HEIGHT:  plot_height_reg  <= cfg_data[HGT_W-1:0];
                    CFG_WINDOW_WIDTH: window_width_reg <= cfg_data[OFS_W-1:0];
                    default: ;
                endcase
            end
            if (ram_we)
            begin
                stored_seq_reg <= packet_seq;
                wp_reg         <= wp_reg + PTR_W'(1);
                if (wp_reg == PTR_W'(RING_DEPTH - 1))
                begin
                    wrapped_reg <= 1'b1;
                end
            end
            if (ctl.step)
            begin
                if (sts.hit)
                    start_off_reg <= off_reg[OFS_W-1:0];
                else if (sts.last)
                    start_off_reg <= window_width_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        // entries never written read as zero
        ent_ok_reg <= wrapped_reg || (idx_reg < wp_reg);

        if (ctl.take)
        begin
            kind_reg <= (op == CMD_READ) ? RPL_COLUMN : RPL_TRIGGER;
            idx_reg  <= (op == CMD_READ) ? read_idx : search_idx;
            off_reg  <= w_ext;
            cnt_reg  <= limit[PTR_W-1:0];
        end
        else if (ctl.prime)
        begin
            newer_ok_reg <= !older_neg;
            idx_reg      <= idx_reg - PTR_W'(1);
        end
        else if (ctl.step && !sts.hit && !sts.last)
        begin
            // advance one offset further back
            newer_ok_reg <= !older_neg;
            idx_reg      <= idx_reg - PTR_W'(1);
            off_reg      <= off_reg + OFF_W'(1);
            cnt_reg      <= cnt_reg - PTR_W'(1);
        end

        if (ctl.rd_calc)
        begin
            left_res_reg  <= sample_row(ent_ok_reg ? rd_left : '0,
                                        plot_top_reg, plot_height_reg);
            right_res_reg <= sample_row(ent_ok_reg ? rd_right : '0,
                                        plot_top_reg, plot_height_reg);
        end

        if (ctl.load_out)
        begin
            reply_kind_reg     <= kind_reg;
            trigger_offset_reg <= start_off_reg;
            left_y_reg         <= (kind_reg == RPL_COLUMN) ? left_res_reg : '0;
            right_y_reg        <= (kind_reg == RPL_COLUMN) ? right_res_reg : '0;
        end
    end

    assign reply_kind     = reply_kind_reg;
    assign trigger_offset = trigger_offset_reg;
    assign left_y         = left_y_reg;
    assign right_y        = right_y_reg;

    `SRTC_ASSERT_NEXT(a_wp_only_on_push, !ram_we, $stable(wp_reg),
        "write pointer moved without a push")
    `SRTC_ASSERT_NEXT(a_wrapped_sticky, wrapped_reg, wrapped_reg,
        "ring wrap flag cleared")
    `SRTC_ASSERT_NEXT(a_offset_only_on_search, !ctl.step, $stable(start_off_reg),
        "start offset changed outside a search")

endmodule

>>> src/scope_ring_trigger_capture.sv
// Top level of the two-channel scope capture with rising-edge trigger.
// Depends on srtc_pkg, srtc_ctrl, srtc_dp (and through it srtc_ram).
//
// Request channel (req_valid/req_stall) carries cmd, packet_seq, left_sample,
// right_sample and column; a request is taken when req_valid is high and
// req_stall low. Reply channel (rsp_valid/rsp_stall) carries reply_kind,
// trigger_offset, left_y and right_y.
// Push (cmd 0): the pair is written at the write pointer unless its sequence
//   number repeats the last one stored. No reply.
// Column read (cmd 2): S_RD_MEM, S_RD_DATA, then S_OUT loads the reply register.
// Trigger search (cmd 1): each checked offset takes one RAM read (S_SR_MEM)
//   and one compare (S_SR_DATA); the search stops at a rising crossing or at
//   the last offset, at most max(1, RING_DEPTH/2 - window_width) offsets.
// No-op (cmd 3): no reply.
// req_stall is high while a search or read is in progress. The reply sits in
// an output register: pushes are still taken while it waits, and a new reply
// waits until the previous one has been taken when rsp_stall is high.
// Config writes (cfg_valid/cfg_ready, cfg_index, cfg_data) are always ready.
// Reset clears the ring logically at once (a wrap flag and the write pointer
// mark unwritten entries as zero), so the block is usable right after reset.
module scope_ring_trigger_capture
    import srtc_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       req_valid,
    output logic                       req_stall,
    input  logic [1:0]                 cmd,
    input  logic [SEQ_W-1:0]           packet_seq,
    input  logic signed [SAMPLE_W-1:0] left_sample,
    input  logic signed [SAMPLE_W-1:0] right_sample,
    input  logic [COL_W-1:0]           column,
    output logic                       rsp_valid,
    input  logic                       rsp_stall,
    output logic                       reply_kind,
    output logic [OFS_W-1:0]           trigger_offset,
    output logic [ROW_W-1:0]           left_y,
    output logic [ROW_W-1:0]           right_y,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFGIDX_W-1:0]        cfg_index,
    input  logic [CFG_W-1:0]           cfg_data
);

    srtc_ctl_t ctl;
    srtc_sts_t sts;

    assign cfg_ready = 1'b1;

    srtc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .cmd       (cmd),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .sts       (sts),
        .ctl       (ctl)
    );

    srtc_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctl            (ctl),
        .sts            (sts),
        .cmd            (cmd),
        .packet_seq     (packet_seq),
        .left_sample    (left_sample),
        .right_sample   (right_sample),
        .column         (column),
        .cfg_valid      (cfg_valid && cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .reply_kind     (reply_kind),
        .trigger_offset (trigger_offset),
        .left_y         (left_y),
        .right_y        (right_y)
    );

endmodule
